// ----- hw/rtl/bsc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the barometric compensation block.
// Used by bsc_front, bsc_queue, bsc_back and the top level; depends on nothing else.
package bsc_pkg;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } result_t;

  typedef struct packed {
    logic [47:0] temp_calib;
    logic [63:0] press_calib_low;
    logic [63:0] press_calib_mid;
    logic [15:0] press_calib_high;
  } calib_t;

  // One entry of the queue between the front and the back end.
  typedef struct packed {
    logic signed [15:0] tout;
    logic [63:0]        dividend;
    logic [63:0]        divisor;
  } work_t;

  // Partial products of a 64 x 64 multiply, low 64 bits kept.
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  // Running state of the restoring divider.
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] dq;
  } divst_t;

  localparam logic [7:0]  CFG_TEMP_CALIB       = 8'd0;
  localparam logic [7:0]  CFG_PRESS_CALIB_LOW  = 8'd1;
  localparam logic [7:0]  CFG_PRESS_CALIB_MID  = 8'd2;
  localparam logic [7:0]  CFG_PRESS_CALIB_HIGH = 8'd3;

  localparam logic [63:0] T_FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_SCALE   = 64'd3125;
  localparam logic [63:0] PRESS_BASE    = 64'd1048576;

  localparam int FRONT_STAGES = 13;
  localparam int DIV_STEPS    = 64;

  function automatic logic [63:0] sext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    r.lh = a[31:0] * b[63:32];
    r.hl = a[63:32] * b[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    logic [31:0] mid;
    mid = p.lh + p.hl;
    return p.ll + {mid, 32'd0};
  endfunction

  function automatic divst_t div_step(input divst_t s, input logic [63:0] ub);
    logic [64:0] t;
    divst_t      r;
    t = {s.rem, s.dq[63]};
    if (t >= {1'b0, ub}) begin
      r.rem = 64'(t - {1'b0, ub});
      r.dq  = {s.dq[62:0], 1'b1};
    end else begin
      r.rem = t[63:0];
      r.dq  = {s.dq[62:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/barometric_sensor_compensation.sv -----
// Top level of the barometric compensation block: configuration registers and the credit
// counter that ties bsc_front, bsc_queue and bsc_back together; uses bsc_pkg.
//
// Usage:
//   The sample channel (sample_valid, sample_stall, sample) takes one raw pressure and
//   temperature pair per beat. The result channel (result_valid, result_stall, result)
//   returns one compensated beat per sample, in order. Calibration words are written on
//   the cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data), index 0 to 3; other
//   indexes are ignored. cfg_ready is always high; write only while the block is idle.
//   The path holds 86 register stages, the first loaded at the accepting edge: 13 front
//   stages, the queue register, one operand stage, 64 steps of the pipelined divider and
//   7 stages of pressure correction including the output register. Throughput is one
//   beat per cycle while neither stall is raised, set by the one-step-per-stage divider
//   and fully pipelined multipliers.
//   A stalled result freezes the back end; the front keeps running into the queue until
//   QUEUE_DEPTH beats are in flight in front and queue together, then sample_stall rises.
//   Reset (rst, synchronous) clears calibration to zero and empties all pipelines.
module barometric_sensor_compensation import bsc_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int USED_W = $clog2(QUEUE_DEPTH + 1);

  calib_t            calib;
  logic              accept;
  logic              front_valid;
  work_t             front_item;
  logic              pop;
  logic              q_empty;
  work_t             q_item;
  logic [USED_W-1:0] used;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (used == USED_W'(QUEUE_DEPTH));
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP_CALIB:       calib.temp_calib       <= cfg_data[47:0];
        CFG_PRESS_CALIB_LOW:  calib.press_calib_low  <= cfg_data;
        CFG_PRESS_CALIB_MID:  calib.press_calib_mid  <= cfg_data;
        CFG_PRESS_CALIB_HIGH: calib.press_calib_high <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Counts samples in the front pipeline plus entries in the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (accept && !pop) begin
      used <= used + 1'b1;
    end else if (pop && !accept) begin
      used <= used - 1'b1;
    end
  end

  bsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .calib     (calib),
    .in_valid  (accept),
    .in_item   (sample),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  bsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  bsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .calib        (calib),
    .q_empty      (q_empty),
    .q_item       (q_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- hw/rtl/bsc_front.sv -----
// Front end: temperature compensation and preparation of the pressure division operands.
// Free-running 13-stage pipeline; uses bsc_pkg.
module bsc_front import bsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  calib_t  calib,
  input  logic    in_valid,
  input  sample_t in_item,
  output logic    out_valid,
  output work_t   out_item
);

  logic [FRONT_STAGES-1:0] vld;

  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6;

  logic [31:0] s1_a, s1_b;
  logic [19:0] s1_rawp, s2_rawp, s3_rawp, s4_rawp, s5_rawp, s6_rawp;
  logic [19:0] s7_rawp, s8_rawp, s9_rawp, s10_rawp;
  logic [31:0] s2_m1, s2_bb;
  logic [31:0] s3_v1t, s3_m2;
  logic [31:0] s4_tf;
  logic [63:0] s5_v1;
  logic signed [15:0] s5_tout, s6_tout, s7_tout, s8_tout, s9_tout;
  logic signed [15:0] s10_tout, s11_tout, s12_tout, s13_tout;
  pp_t         s6_pvv, s6_pv5, s6_pv2;
  logic [63:0] s7_vv, s7_v1p5, s7_v1p2;
  pp_t         s8_pvv6, s8_pvv3;
  logic [63:0] s8_v1p5, s8_v1p2;
  logic [63:0] s9_vvp6, s9_vvp3, s9_v1p5, s9_v1p2;
  logic [63:0] s10_v2, s10_y;
  pp_t         s11_py1;
  logic [63:0] s11_num;
  logic [63:0] s12_div;
  pp_t         s12_pnum;
  logic [63:0] s13_dividend, s13_divisor;

  logic [31:0]        tc;
  logic signed [15:0] tout_sat;

  assign t1 = {16'd0, calib.temp_calib[15:0]};
  assign t2 = {{16{calib.temp_calib[31]}}, calib.temp_calib[31:16]};
  assign t3 = {{16{calib.temp_calib[47]}}, calib.temp_calib[47:32]};
  assign p1 = {48'd0, calib.press_calib_low[15:0]};
  assign p2 = sext16(calib.press_calib_low[31:16]);
  assign p3 = sext16(calib.press_calib_low[47:32]);
  assign p4 = sext16(calib.press_calib_low[63:48]);
  assign p5 = sext16(calib.press_calib_mid[15:0]);
  assign p6 = sext16(calib.press_calib_mid[31:16]);

  always_comb begin
    tc = 32'($signed(s4_tf * 32'd5 + 32'd128) >>> 8);
    priority if ($signed(tc) < -32'sd32768) begin
      tout_sat = 16'sh8000;
    end else if ($signed(tc) > 32'sd32767) begin
      tout_sat = 16'sh7fff;
    end else begin
      tout_sat = tc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // Temperature path, 32-bit wrapping arithmetic.
    s1_a    <= {15'd0, in_item.raw_temperature[19:3]} - {15'd0, t1[15:0], 1'b0};
    s1_b    <= {16'd0, in_item.raw_temperature[19:4]} - t1;
    s1_rawp <= in_item.raw_pressure;

    s2_m1   <= s1_a * t2;
    s2_bb   <= s1_b * s1_b;
    s2_rawp <= s1_rawp;

    s3_v1t  <= 32'($signed(s2_m1) >>> 11);
    s3_m2   <= 32'($signed(s2_bb) >>> 12) * t3;
    s3_rawp <= s2_rawp;

    s4_tf   <= s3_v1t + 32'($signed(s3_m2) >>> 14);
    s4_rawp <= s3_rawp;

    s5_v1   <= {{32{s4_tf[31]}}, s4_tf} - T_FINE_OFFSET;
    s5_tout <= tout_sat;
    s5_rawp <= s4_rawp;

    // Pressure path, 64-bit wrapping arithmetic split into 32-bit partial products.
    s6_pvv  <= mul_pp(s5_v1, s5_v1);
    s6_pv5  <= mul_pp(s5_v1, p5);
    s6_pv2  <= mul_pp(s5_v1, p2);
    s6_tout <= s5_tout;
    s6_rawp <= s5_rawp;

    s7_vv   <= mul_sum(s6_pvv);
    s7_v1p5 <= mul_sum(s6_pv5);
    s7_v1p2 <= mul_sum(s6_pv2);
    s7_tout <= s6_tout;
    s7_rawp <= s6_rawp;

    s8_pvv6 <= mul_pp(s7_vv, p6);
    s8_pvv3 <= mul_pp(s7_vv, p3);
    s8_v1p5 <= s7_v1p5;
    s8_v1p2 <= s7_v1p2;
    s8_tout <= s7_tout;
    s8_rawp <= s7_rawp;

    s9_vvp6 <= mul_sum(s8_pvv6);
    s9_vvp3 <= mul_sum(s8_pvv3);
    s9_v1p5 <= s8_v1p5;
    s9_v1p2 <= s8_v1p2;
    s9_tout <= s8_tout;
    s9_rawp <= s8_rawp;

    s10_v2   <= s9_vvp6 + (s9_v1p5 << 17) + (p4 << 35);
    s10_y    <= 64'($signed(s9_vvp3) >>> 8) + (s9_v1p2 << 12) + (64'd1 << 47);
    s10_tout <= s9_tout;
    s10_rawp <= s9_rawp;

    s11_py1  <= mul_pp(s10_y, p1);
    s11_num  <= ((PRESS_BASE - {44'd0, s10_rawp}) << 31) - s10_v2;
    s11_tout <= s10_tout;

    s12_div  <= 64'($signed(mul_sum(s11_py1)) >>> 33);
    s12_pnum <= mul_pp(s11_num, PRESS_SCALE);
    s12_tout <= s11_tout;

    s13_dividend <= mul_sum(s12_pnum);
    s13_divisor  <= s12_div;
    s13_tout     <= s12_tout;
  end

  assign out_valid         = vld[FRONT_STAGES-1];
  assign out_item.tout     = s13_tout;
  assign out_item.dividend = s13_dividend;
  assign out_item.divisor  = s13_divisor;

endmodule

// ----- hw/rtl/bsc_queue.sv -----
// Small FIFO of prepared work between the front and the back end.
// Register storage with a combinational head; uses bsc_pkg for the entry type.
module bsc_queue import bsc_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_item,
  input  logic  pop,
  output work_t pop_item,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign pop_item = mem[rd_ptr];
  assign empty    = (cnt == '0);

  // The credit counter upstream must keep the queue from ever overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && cnt == CNT_W'(DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != '0)
    else $error("queue pop while empty");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0 && cnt != CNT_W'(DEPTH)) |-> rd_ptr != wr_ptr)
    else $error("queue pointers disagree with occupancy");

endmodule

// ----- hw/rtl/bsc_back.sv -----
// Back end: pipelined 64-bit signed division, pressure correction and the output register.
// Stalls as a whole when the output register is held; uses bsc_pkg.
module bsc_back import bsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  calib_t  calib,
  input  logic    q_empty,
  input  work_t   q_item,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef struct packed {
    logic signed [15:0] tout;
    logic               neg;
    logic               zero;
  } meta_t;

  logic en;

  logic        b0_valid;
  divst_t      b0_st;
  logic [63:0] b0_ub;
  meta_t       b0_meta;

  logic [DIV_STEPS-1:0] dv_valid;
  divst_t      dv_st   [DIV_STEPS];
  logic [63:0] dv_ub   [DIV_STEPS];
  meta_t       dv_meta [DIV_STEPS];

  logic [5:0]  pv;
  meta_t       p0_meta, p1_meta, p2_meta, p3_meta, p4_meta, p5_meta;
  logic [63:0] p0_p, p1_p, p2_p, p3_p, p4_p, p5_s;
  pp_t         p1_pss, p1_p8;
  logic [63:0] p2_psps, p2_p8p, p3_p8p, p4_p8p, p4_w1;
  pp_t         p3_p9;

  logic [63:0] p7, p8, p9, ps, fin;
  logic        na, nb;
  result_t     res_next;

  assign p7 = sext16(calib.press_calib_mid[47:32]);
  assign p8 = sext16(calib.press_calib_mid[63:48]);
  assign p9 = sext16(calib.press_calib_high);

  assign en  = !result_valid || !result_stall;
  assign pop = en && !q_empty;
  assign na  = q_item.dividend[63];
  assign nb  = q_item.divisor[63];
  assign ps  = 64'($signed(p0_p) >>> 13);

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid     <= 1'b0;
      dv_valid     <= '0;
      pv           <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      b0_valid     <= !q_empty;
      dv_valid     <= {dv_valid[DIV_STEPS-2:0], b0_valid};
      pv           <= {pv[4:0], dv_valid[DIV_STEPS-1]};
      result_valid <= pv[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Divide magnitudes; the sign is applied after the last step.
      b0_st.rem    <= '0;
      b0_st.dq     <= na ? -q_item.dividend : q_item.dividend;
      b0_ub        <= nb ? -q_item.divisor : q_item.divisor;
      b0_meta.tout <= q_item.tout;
      b0_meta.neg  <= na ^ nb;
      b0_meta.zero <= (q_item.divisor == '0);

      dv_st[0]   <= div_step(b0_st, b0_ub);
      dv_ub[0]   <= b0_ub;
      dv_meta[0] <= b0_meta;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_st[k]   <= div_step(dv_st[k-1], dv_ub[k-1]);
        dv_ub[k]   <= dv_ub[k-1];
        dv_meta[k] <= dv_meta[k-1];
      end

      p0_p    <= dv_meta[DIV_STEPS-1].neg ? -dv_st[DIV_STEPS-1].dq : dv_st[DIV_STEPS-1].dq;
      p0_meta <= dv_meta[DIV_STEPS-1];

      p1_pss  <= mul_pp(ps, ps);
      p1_p8   <= mul_pp(p8, p0_p);
      p1_p    <= p0_p;
      p1_meta <= p0_meta;

      p2_psps <= mul_sum(p1_pss);
      p2_p8p  <= mul_sum(p1_p8);
      p2_p    <= p1_p;
      p2_meta <= p1_meta;

      p3_p9   <= mul_pp(p9, p2_psps);
      p3_p8p  <= p2_p8p;
      p3_p    <= p2_p;
      p3_meta <= p2_meta;

      p4_w1   <= 64'($signed(mul_sum(p3_p9)) >>> 25);
      p4_p8p  <= p3_p8p;
      p4_p    <= p3_p;
      p4_meta <= p3_meta;

      p5_s    <= p4_p + p4_w1 + 64'($signed(p4_p8p) >>> 19);
      p5_meta <= p4_meta;

      result  <= res_next;
    end
  end

  always_comb begin
    fin = 64'($signed(p5_s) >>> 8) + (p7 << 4);
    res_next.temperature_centi = p5_meta.tout;
    priority if (p5_meta.zero) begin
      res_next.pressure_q24_8 = '0;
      res_next.pressure_valid = 1'b0;
    end else if (fin[63]) begin
      res_next.pressure_q24_8 = '0;
      res_next.pressure_valid = 1'b1;
    end else if (fin[63:32] != '0) begin
      res_next.pressure_q24_8 = '1;
      res_next.pressure_valid = 1'b1;
    end else begin
      res_next.pressure_q24_8 = fin[31:0];
      res_next.pressure_valid = 1'b1;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for barometric_sensor_compensation: drives raw sample beats,
// predicts each compensated result in its own model of the arithmetic, and checks in order.
// Depends on bsc_pkg (payload types and register indexes) and the block's RTL.
module tb_top import bsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  sample_t     sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  calib_t  calib = '0;
  result_t expected_results[$];
  bit      failed = 1'b0;
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;
  int      hold_off_cycles = 0;

  barometric_sensor_compensation DUT (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  // Truncating signed division; the most negative value over -1 wraps to itself.
  function automatic logic [63:0] divide_trunc(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic result_t compensate(input sample_t s, input calib_t c);
    logic [31:0] t1, t2, t3, a, b, v1t, v2t, tf, tc;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, p, ps, w1, w2;
    result_t r;
    t1 = {16'd0, c.temp_calib[15:0]};
    t2 = {{16{c.temp_calib[31]}}, c.temp_calib[31:16]};
    t3 = {{16{c.temp_calib[47]}}, c.temp_calib[47:32]};
    p1 = {48'd0, c.press_calib_low[15:0]};
    p2 = sext16(c.press_calib_low[31:16]);
    p3 = sext16(c.press_calib_low[47:32]);
    p4 = sext16(c.press_calib_low[63:48]);
    p5 = sext16(c.press_calib_mid[15:0]);
    p6 = sext16(c.press_calib_mid[31:16]);
    p7 = sext16(c.press_calib_mid[47:32]);
    p8 = sext16(c.press_calib_mid[63:48]);
    p9 = sext16(c.press_calib_high);

    a = {12'd0, s.raw_temperature} >> 3;
    a = a - (t1 << 1);
    v1t = sra32(a * t2, 11);
    b = ({12'd0, s.raw_temperature} >> 4) - t1;
    v2t = sra32(sra32(b * b, 12) * t3, 14);
    tf = v1t + v2t;
    tc = sra32(tf * 32'd5 + 32'd128, 8);
    if ($signed(tc) < -32768) r.temperature_centi = 16'sh8000;
    else if ($signed(tc) > 32767) r.temperature_centi = 16'sh7fff;
    else r.temperature_centi = tc[15:0];

    v1 = {{32{tf[31]}}, tf} - T_FINE_OFFSET;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64(((64'd1 << 47) + v1) * p1, 33);

    r.pressure_q24_8 = '0;
    r.pressure_valid = 1'b0;
    if (v1 != 0) begin
      p = PRESS_BASE - {44'd0, s.raw_pressure};
      p = divide_trunc(((p << 31) - v2) * PRESS_SCALE, v1);
      ps = sra64(p, 13);
      w1 = sra64(p9 * ps * ps, 25);
      w2 = sra64(p8 * p, 19);
      p = sra64(p + w1 + w2, 8) + (p7 << 4);
      if (p[63]) r.pressure_q24_8 = '0;
      else if (p > 64'hffff_ffff) r.pressure_q24_8 = 32'hffff_ffff;
      else r.pressure_q24_8 = p[31:0];
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  // Receiver: a long hold-off takes priority over random stalls.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      result_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation pending: %h", result);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.temperature_centi !== exp_r.temperature_centi) begin
          $error("temperature_centi expected %0d actual %0d",
                 exp_r.temperature_centi, result.temperature_centi);
          failed = 1'b1;
        end
        if (result.pressure_q24_8 !== exp_r.pressure_q24_8) begin
          $error("pressure_q24_8 expected %0d actual %0d",
                 exp_r.pressure_q24_8, result.pressure_q24_8);
          failed = 1'b1;
        end
        if (result.pressure_valid !== exp_r.pressure_valid) begin
          $error("pressure_valid expected %0b actual %0b",
                 exp_r.pressure_valid, result.pressure_valid);
          failed = 1'b1;
        end
      end
    end
  end

  // Valid stays high from one beat into the next unless a gap is drawn.
  task automatic send_sample(input logic [19:0] rawp, input logic [19:0] rawt);
    sample_t s;
    s.raw_pressure = rawp;
    s.raw_temperature = rawt;
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    expected_results.push_back(compensate(s, calib));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TEMP_CALIB:       calib.temp_calib = data[47:0];
      CFG_PRESS_CALIB_LOW:  calib.press_calib_low = data;
      CFG_PRESS_CALIB_MID:  calib.press_calib_mid = data;
      CFG_PRESS_CALIB_HIGH: calib.press_calib_high = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_calib(input calib_t c);
    wait_idle();
    write_reg(CFG_TEMP_CALIB, {16'd0, c.temp_calib});
    write_reg(CFG_PRESS_CALIB_LOW, c.press_calib_low);
    write_reg(CFG_PRESS_CALIB_MID, c.press_calib_mid);
    write_reg(CFG_PRESS_CALIB_HIGH, {48'd0, c.press_calib_high});
  endtask

  // Factory-style coefficients, optionally jittered.
  function automatic calib_t typical_calib(input int jitter);
    calib_t c;
    c.temp_calib = {16'(-1000 + $urandom_range(2 * jitter) - jitter),
                    16'(26435 + $urandom_range(2 * jitter) - jitter),
                    16'(27504 + $urandom_range(2 * jitter) - jitter)};
    c.press_calib_low = {16'(2855), 16'(3024), 16'(-10685),
                         16'(36477 + $urandom_range(2 * jitter) - jitter)};
    c.press_calib_mid = {16'(-14600), 16'(15500), 16'(-7), 16'(140)};
    c.press_calib_high = 16'(6000);
    return c;
  endfunction

  task automatic send_random_sample();
    if ($urandom_range(1))
      send_sample(20'($urandom_range(500000, 250000)), 20'($urandom_range(560000, 480000)));
    else
      send_sample(20'($urandom), 20'($urandom));
  endtask

  task automatic test_reset_calibration();
    // All coefficients are zero, so the divisor is zero for every sample.
    send_sample(20'd0, 20'd0);
    send_sample(20'hfffff, 20'hfffff);
    send_sample(20'd415148, 20'd519888);
  endtask

  task automatic test_typical_calibration();
    load_calib(typical_calib(0));
    send_sample(20'd415148, 20'd519888);
    send_sample(20'd0, 20'd519888);
    send_sample(20'hfffff, 20'd519888);
    send_sample(20'd415148, 20'd0);
    send_sample(20'd415148, 20'hfffff);
    send_sample(20'h55555, 20'haaaaa);
  endtask

  task automatic test_extreme_calibration();
    calib_t c;
    c = '1;
    load_calib(c);
    send_sample(20'd0, 20'hfffff);
    send_sample(20'hfffff, 20'd0);
    c.temp_calib = {16'h8000, 16'h8000, 16'hffff};
    c.press_calib_low = {16'h8000, 16'h8000, 16'h8000, 16'hffff};
    c.press_calib_mid = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
    c.press_calib_high = 16'h7fff;
    load_calib(c);
    send_sample(20'd0, 20'd0);
    send_sample(20'hfffff, 20'hfffff);
    send_sample(20'h80000, 20'd519888);
    // Writes to unused indexes must leave calibration untouched.
    wait_idle();
    write_reg(8'd4, '1);
    write_reg(8'hff, 64'h0);
    send_sample(20'd415148, 20'd519888);
    send_sample(20'd0, 20'hfffff);
  endtask

  task automatic test_zero_divisor();
    calib_t c;
    c = typical_calib(0);
    c.press_calib_low[15:0] = 16'd0;
    load_calib(c);
    send_sample(20'd415148, 20'd519888);
    send_sample(20'hfffff, 20'd0);
    send_sample(20'd0, 20'hfffff);
  endtask

  task automatic test_random_traffic();
    int idle_pct [4] = '{0, 68, 0, 33};
    int stall_pct [4] = '{0, 0, 68, 33};
    calib_t c;
    for (int round = 0; round < 8; round++) begin
      if (round % 2 == 0) c = typical_calib(2000);
      else c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      load_calib(c);
      sender_idle_pct = idle_pct[round % 4];
      receiver_stall_pct = stall_pct[round % 4];
      repeat (140) send_random_sample();
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  // Enough beats to fill the back end, the queue and the front while the receiver holds off.
  task automatic test_backpressure();
    load_calib(typical_calib(500));
    @(negedge clk);
    hold_off_cycles = 300;
    repeat (130) send_random_sample();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_calibration();
    test_typical_calibration();
    test_extreme_calibration();
    test_zero_divisor();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_front.sv
hw/rtl/bsc_queue.sv
hw/rtl/bsc_back.sv
hw/rtl/barometric_sensor_compensation.sv
dv/tb_top.sv
